// ===== hdl/assert_macros.svh =====
// Assertion helpers for the checker in sfr_chk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define SFR_ASSERT_NOW(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sfr check failed");

// next-cycle implication
`define SFR_ASSERT_NEXT(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sfr check failed");

`endif

// ===== hdl/sfr_pkg.sv =====
package sfr_pkg;

	localparam int MAX_PATTERN  = 8;
	localparam int COUNT_WIDTH  = 16;
	localparam int REPORT_WIDTH = 16;
	localparam int WIN_W        = MAX_PATTERN * 8;
	localparam int HELD_W       = $clog2(MAX_PATTERN + 1);
	localparam int CFG_DATA_W   = 64;
	localparam int CFG_ADDR_W   = 5;
	localparam int LEN_W        = 4;

	typedef enum logic [1:0] {
		REG_PATTERN_BYTES,
		REG_PATTERN_LENGTH,
		REG_REPLACEMENT_BYTES,
		REG_REPLACEMENT_LENGTH
	} reg_idx_t;

	typedef struct packed {
		logic [63:0]       pattern;
		logic [HELD_W-1:0] plen;     // effective, 1..MAX_PATTERN
		logic [63:0]       repl;
		logic [LEN_W-1:0]  rlen;     // effective, 0..8
		logic              plen_wr;  // pattern length written this cycle
	} cfg_t;

	typedef struct packed {
		logic load;
		logic push_win;
		logic push_repl;
		logic match_done;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic prefix_ok;
		logic full_match;
		logic held_zero;
		logic rlen_zero;
		logic repl_end;
		logic last;
		logic can_push;
		logic fin_ok;
	} sts_t;

endpackage

// ===== hdl/sfr_if.sv =====
interface sfr_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_char;
	logic       in_last;

	modport source (output valid, output in_char, output in_last, input ready);
	modport sink (input valid, input in_char, input in_last, output ready);
endinterface

interface sfr_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  out_char;
	logic        out_valid;
	logic        out_last;
	logic [15:0] out_length;
	logic [15:0] replaced_total;

	modport source (output valid, output out_char, output out_valid, output out_last,
		output out_length, output replaced_total, input ready);
	modport sink (input valid, input out_char, input out_valid, input out_last,
		input out_length, input replaced_total, output ready);
endinterface

// ===== hdl/sfr_regs.sv =====
module sfr_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [sfr_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [sfr_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [sfr_pkg::CFG_DATA_W-1:0] prdata,
	output logic                           pready,
	output sfr_pkg::cfg_t                  cfg
);
	import sfr_pkg::*;

	logic [63:0]      pattern_q;
	logic [LEN_W-1:0] plen_q;
	logic [63:0]      repl_q;
	logic [LEN_W-1:0] rlen_q;
	logic             wr;
	reg_idx_t         idx;
	logic [LEN_W-1:0] plen_eff;
	logic [LEN_W-1:0] rlen_eff;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= '0;
			plen_q    <= LEN_W'(1);
			repl_q    <= '0;
			rlen_q    <= '0;
		end else if (wr) begin
			unique case (idx)
				REG_PATTERN_BYTES:      pattern_q <= pwdata[63:0];
				REG_PATTERN_LENGTH:     plen_q    <= pwdata[LEN_W-1:0];
				REG_REPLACEMENT_BYTES:  repl_q    <= pwdata[63:0];
				REG_REPLACEMENT_LENGTH: rlen_q    <= pwdata[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_PATTERN_BYTES:      prdata = CFG_DATA_W'(pattern_q);
			REG_PATTERN_LENGTH:     prdata = CFG_DATA_W'(plen_q);
			REG_REPLACEMENT_BYTES:  prdata = CFG_DATA_W'(repl_q);
			REG_REPLACEMENT_LENGTH: prdata = CFG_DATA_W'(rlen_q);
			default:                prdata = '0;
		endcase
	end

	// zero pattern length acts as one, anything beyond the window acts as full window; replacement length caps at 8
	always_comb begin
		plen_eff = plen_q;
		if (plen_q == '0)
			plen_eff = LEN_W'(1);
		else if (plen_q > LEN_W'(MAX_PATTERN))
			plen_eff = LEN_W'(MAX_PATTERN);
		rlen_eff = (rlen_q > LEN_W'(8)) ? LEN_W'(8) : rlen_q;
	end

	assign cfg.pattern = pattern_q;
	assign cfg.plen    = HELD_W'(plen_eff);
	assign cfg.repl    = repl_q;
	assign cfg.rlen    = rlen_eff;
	assign cfg.plen_wr = wr && (idx == REG_PATTERN_LENGTH);

endmodule

// ===== hdl/sfr_ctrl.sv =====
module sfr_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  sfr_pkg::sts_t sts,
	output sfr_pkg::cmd_t cmd
);
	import sfr_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_REPL,
		ST_FLUSH,
		ST_FINISH
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   in_ready_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && in_ready_q) begin
					cmd.load = 1'b1;
					state_d  = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (sts.full_match) begin
					if (sts.rlen_zero)
						cmd.match_done = 1'b1;
					else
						state_d = ST_REPL;
				end else if (sts.prefix_ok) begin
					state_d = sts.last ? ST_FLUSH : ST_FINISH;
				end else if (sts.can_push) begin
					cmd.push_win = 1'b1;
				end
			end
			ST_REPL: begin
				if (sts.can_push) begin
					cmd.push_repl = 1'b1;
					if (sts.repl_end) begin
						cmd.match_done = 1'b1;
						state_d        = ST_SCAN;
					end
				end
			end
			ST_FLUSH: begin
				if (sts.held_zero)
					state_d = ST_FINISH;
				else if (sts.can_push)
					cmd.push_win = 1'b1;
			end
			ST_FINISH: begin
				if (sts.fin_ok) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			in_ready_q <= 1'b1;
		end else begin
			state_q    <= state_d;
			in_ready_q <= (state_d == ST_IDLE);
		end
	end

	assign in_ready = in_ready_q;

endmodule

// ===== hdl/sfr_dp.sv =====
module sfr_dp (
	input  logic          clk,
	input  logic          arst_n,
	input  sfr_pkg::cfg_t cfg,
	input  sfr_pkg::cmd_t cmd,
	output sfr_pkg::sts_t sts,
	input  logic [7:0]    in_char,
	input  logic          in_last,
	output logic          out_full,
	input  logic          out_ready,
	output logic [7:0]    out_char,
	output logic          out_valid,
	output logic          out_last,
	output logic [15:0]   out_length,
	output logic [15:0]   replaced_total
);
	import sfr_pkg::*;

	function automatic logic [REPORT_WIDTH-1:0] report(input logic [COUNT_WIDTH-1:0] v);
		if (COUNT_WIDTH > REPORT_WIDTH && v > COUNT_WIDTH'({REPORT_WIDTH{1'b1}}))
			return '1;
		return REPORT_WIDTH'(v);
	endfunction

	logic [WIN_W-1:0]       win_q;
	logic [HELD_W-1:0]      held_q;
	logic                   last_q;
	logic [2:0]             idx_q;
	logic [COUNT_WIDTH-1:0] written_q;
	logic [COUNT_WIDTH-1:0] match_q;
	// pending byte: held back one emission so the final one can carry the end mark
	logic [7:0]             pend_q;
	logic                   pend_full_q;
	logic [7:0]             oc_q;
	logic                   ov_q;
	logic                   ol_q;
	logic [15:0]            olen_q;
	logic [15:0]            orep_q;
	logic                   ofull_q;

	logic [HELD_W-1:0]      cmp;
	logic [MAX_PATTERN-1:0] hit;
	logic                   out_free;
	logic                   push;
	logic [7:0]             push_byte;
	logic                   rel_pend;
	logic                   fin_out;

	assign cmp = (held_q < cfg.plen) ? held_q : cfg.plen;

	always_comb begin
		for (int i = 0; i < MAX_PATTERN; i++)
			hit[i] = (HELD_W'(i) >= cmp) || (win_q[8*i +: 8] == cfg.pattern[8*i +: 8]);
	end

	assign out_free  = !ofull_q || out_ready;
	assign push      = cmd.push_win || cmd.push_repl;
	assign push_byte = cmd.push_win ? win_q[7:0] : cfg.repl[{idx_q, 3'b000} +: 8];
	assign rel_pend  = push && pend_full_q;
	assign fin_out   = cmd.finish && (pend_full_q || last_q);

	assign sts.prefix_ok  = &hit;
	assign sts.full_match = (&hit) && (held_q >= cfg.plen);
	assign sts.held_zero  = (held_q == '0);
	assign sts.rlen_zero  = (cfg.rlen == '0);
	assign sts.repl_end   = ({1'b0, idx_q} == (cfg.rlen - LEN_W'(1)));
	assign sts.last       = last_q;
	assign sts.can_push   = !pend_full_q || out_free;
	assign sts.fin_ok     = !(pend_full_q || last_q) || out_free;

	// window and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q    <= '0;
			last_q    <= 1'b0;
			idx_q     <= '0;
			written_q <= '0;
			match_q   <= '0;
		end else begin
			if (cfg.plen_wr) begin
				held_q <= '0;
			end else if (cmd.load) begin
				if (held_q < HELD_W'(MAX_PATTERN))
					held_q <= held_q + HELD_W'(1);
				last_q <= in_last;
			end else if (cmd.push_win) begin
				held_q <= held_q - HELD_W'(1);
			end else if (cmd.match_done) begin
				held_q <= held_q - cfg.plen;
			end

			if (cmd.match_done)
				idx_q <= '0;
			else if (cmd.push_repl)
				idx_q <= idx_q + 3'd1;

			if (cmd.finish && last_q) begin
				written_q <= '0;
				match_q   <= '0;
			end else begin
				if (push && written_q != '1)
					written_q <= written_q + COUNT_WIDTH'(1);
				if (cmd.match_done && match_q != '1)
					match_q <= match_q + COUNT_WIDTH'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load && held_q < HELD_W'(MAX_PATTERN))
			win_q[{held_q[HELD_W-2:0], 3'b000} +: 8] <= in_char;
		else if (cmd.push_win)
			win_q <= win_q >> 8;
		else if (cmd.match_done)
			win_q <= win_q >> {cfg.plen, 3'b000};
	end

	// pending and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_full_q <= 1'b0;
			ofull_q     <= 1'b0;
		end else begin
			if (push)
				pend_full_q <= 1'b1;
			else if (fin_out)
				pend_full_q <= 1'b0;

			if (rel_pend || fin_out)
				ofull_q <= 1'b1;
			else if (out_ready)
				ofull_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			pend_q <= push_byte;

		if (rel_pend) begin
			oc_q   <= pend_q;
			ov_q   <= 1'b1;
			ol_q   <= 1'b0;
			olen_q <= '0;
			orep_q <= '0;
		end else if (fin_out) begin
			oc_q   <= pend_full_q ? pend_q : 8'd0;
			ov_q   <= pend_full_q;
			ol_q   <= last_q;
			olen_q <= last_q ? report(written_q) : 16'd0;
			orep_q <= last_q ? report(match_q) : 16'd0;
		end
	end

	assign out_full       = ofull_q;
	assign out_char       = oc_q;
	assign out_valid      = ov_q;
	assign out_last       = ol_q;
	assign out_length     = olen_q;
	assign replaced_total = orep_q;

endmodule

// ===== hdl/stream_find_replace.sv =====
// An item is accepted while the block is idle and is loaded into the window; the
// scan then makes one decision on the window per step: per output byte, per match
// found, and one more to hand off. No new item is taken until the last is through;
// the final item also passes through the flush. Output stalls hold the scan.
// Reset (arst_n, async, low): window, counters and output empty; registers reset.
module stream_find_replace (
	input  logic                           clk,
	input  logic                           arst_n,
	sfr_in_if.sink                         in_ch,
	sfr_out_if.source                      out_ch,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [sfr_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [sfr_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [sfr_pkg::CFG_DATA_W-1:0] prdata,
	output logic                           pready
);
	import sfr_pkg::*;

	cfg_t cfg;
	cmd_t cmd;
	sts_t sts;
	logic in_ready;
	logic out_full;

	sfr_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	sfr_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_ch.valid),
		.in_ready(in_ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	sfr_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.cmd           (cmd),
		.sts           (sts),
		.in_char       (in_ch.in_char),
		.in_last       (in_ch.in_last),
		.out_full      (out_full),
		.out_ready     (out_ch.ready),
		.out_char      (out_ch.out_char),
		.out_valid     (out_ch.out_valid),
		.out_last      (out_ch.out_last),
		.out_length    (out_ch.out_length),
		.replaced_total(out_ch.replaced_total)
	);

	assign in_ch.ready  = in_ready;
	assign out_ch.valid = out_full;

endmodule

// ===== hdl/sfr_chk.sv =====
`include "assert_macros.svh"

module sfr_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        out_hs_valid,
	input logic        out_hs_ready,
	input logic [7:0]  out_char,
	input logic        out_valid,
	input logic        out_last,
	input logic [15:0] out_length,
	input logic [15:0] replaced_total
);

	// a stalled item keeps its byte and end mark
	`SFR_ASSERT_NEXT(a_out_hold, clk, arst_n, out_hs_valid && !out_hs_ready, out_hs_valid && $stable(out_char) && $stable(out_last))

	// totals only travel with the final item of a text
	`SFR_ASSERT_NOW(a_totals_on_last, clk, arst_n, out_hs_valid && !out_last, out_length == 16'd0 && replaced_total == 16'd0)

	// an item without a byte is the bare end marker
	`SFR_ASSERT_NOW(a_bare_is_last, clk, arst_n, out_hs_valid && !out_valid, out_last && out_char == 8'd0)

	// a final item that carries a byte reports a nonzero length
	`SFR_ASSERT_NOW(a_len_nonzero, clk, arst_n, out_hs_valid && out_last && out_valid, out_length != 16'd0)

endmodule

bind stream_find_replace sfr_chk u_sfr_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_hs_valid  (out_ch.valid),
	.out_hs_ready  (out_ch.ready),
	.out_char      (out_ch.out_char),
	.out_valid     (out_ch.out_valid),
	.out_last      (out_ch.out_last),
	.out_length    (out_ch.out_length),
	.replaced_total(out_ch.replaced_total)
);

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;
	import sfr_pkg::*;

	localparam int SETTLE_CYCLES   = 24;
	localparam int QUIET_LIMIT     = 2000;
	localparam int RANDOM_ITEMS    = 260;
	localparam int RATE_ITEMS      = 40;
	localparam int COUNT_MAX       = (1 << COUNT_WIDTH) - 1;
	localparam int REPORT_MAX      = (1 << REPORT_WIDTH) - 1;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
		logic       drain;   // hold this item back until all results are in
	} text_in_t;

	typedef struct packed {
		logic [7:0]  ch;
		logic        valid;
		logic        last;
		logic [15:0] length;
		logic [15:0] total;
	} text_out_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [CFG_DATA_W-1:0] pwdata;
	logic [CFG_DATA_W-1:0] prdata;
	logic pready;

	sfr_in_if  in_ch();
	sfr_out_if out_ch();

	stream_find_replace i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// shadow of the configuration registers
	logic [63:0] pat_bytes;
	logic [3:0]  pat_len;
	logic [63:0] rep_bytes;
	logic [3:0]  rep_len;

	// predictor state
	logic [7:0] held_bytes [MAX_PATTERN];
	int held_n;
	int bytes_written;
	int matches_found;

	text_in_t  text_q[$];
	text_out_t expected_q[$];

	int predicted_cnt;
	int checked_cnt;
	int items_sent;
	int texts_sent;
	int reg_writes;
	int fail_cnt;
	int idle_max;
	int gap_left;
	int stall_left;
	int n_new;
	int quiet;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int pattern_span();
		if (pat_len == 0) return 1;
		if (pat_len > MAX_PATTERN) return MAX_PATTERN;
		return int'(pat_len);
	endfunction

	function automatic int replace_span();
		return (rep_len > 8) ? 8 : int'(rep_len);
	endfunction

	function automatic text_out_t emitted(input logic [7:0] c);
		text_out_t r;
		r = '{ch: c, valid: 1'b1, last: 1'b0, length: '0, total: '0};
		if (bytes_written < COUNT_MAX) bytes_written++;
		return r;
	endfunction

	// Runs one text byte through the window and queues the bytes it releases.
	task automatic rewrite_byte(input logic [7:0] c, input logic is_last, output int n);
		text_out_t made[$];
		int plen, rlen, cmp, drop, i;
		bit is_prefix, scanning;
		plen = pattern_span();
		rlen = replace_span();
		if (held_n < MAX_PATTERN) begin
			held_bytes[held_n] = c;
			held_n++;
		end
		scanning = 1'b1;
		while (scanning && held_n > 0) begin
			cmp = (held_n < plen) ? held_n : plen;
			is_prefix = 1'b1;
			for (i = 0; i < cmp; i++)
				if (held_bytes[i] != pat_bytes[8*i +: 8]) is_prefix = 1'b0;
			drop = 0;
			if (is_prefix && held_n >= plen) begin
				for (i = 0; i < rlen; i++) made.push_back(emitted(rep_bytes[8*i +: 8]));
				if (matches_found < COUNT_MAX) matches_found++;
				drop = plen;
			end else if (is_prefix) begin
				scanning = 1'b0;
			end else begin
				made.push_back(emitted(held_bytes[0]));
				drop = 1;
			end
			for (i = 0; i + drop < held_n; i++) held_bytes[i] = held_bytes[i + drop];
			held_n -= drop;
		end
		if (is_last) begin
			for (i = 0; i < held_n; i++) made.push_back(emitted(held_bytes[i]));
			held_n = 0;
			// nothing released by this item: bare end marker
			if (made.size() == 0) made.push_back('{ch: '0, valid: 1'b0, last: 1'b0,
				length: '0, total: '0});
			made[made.size()-1].last   = 1'b1;
			made[made.size()-1].length = 16'((bytes_written > REPORT_MAX) ? REPORT_MAX
				: bytes_written);
			made[made.size()-1].total  = 16'((matches_found > REPORT_MAX) ? REPORT_MAX
				: matches_found);
			bytes_written = 0;
			matches_found = 0;
		end
		n = made.size();
		foreach (made[k]) expected_q.push_back(made[k]);
	endtask

	// text source
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid   <= 1'b0;
			in_ch.in_char <= '0;
			in_ch.in_last <= 1'b0;
			gap_left = 0;
		end else begin
			n_new = 0;
			if (in_ch.valid && in_ch.ready) begin
				rewrite_byte(in_ch.in_char, in_ch.in_last, n_new);
				predicted_cnt <= predicted_cnt + n_new;
				items_sent++;
				if (in_ch.in_last) texts_sent++;
				gap_left = $urandom_range(0, idle_max);
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_ch.valid <= 1'b0;
				end else if (text_q.size() > 0 &&
						(!text_q[0].drain || predicted_cnt + n_new == checked_cnt)) begin
					in_ch.valid   <= 1'b1;
					in_ch.in_char <= text_q[0].ch;
					in_ch.in_last <= text_q[0].last;
					void'(text_q.pop_front());
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// result sink and checker
	always @(posedge clk or negedge arst_n) begin
		text_out_t got, want;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				checked_cnt <= checked_cnt + 1;
				got = '{ch: out_ch.out_char, valid: out_ch.out_valid, last: out_ch.out_last,
					length: out_ch.out_length, total: out_ch.replaced_total};
				if (expected_q.size() == 0) begin
					fail_cnt++;
					if (fail_cnt <= 10)
						$display("unexpected result item: char %02h valid %0b last %0b",
							got.ch, got.valid, got.last);
				end else begin
					want = expected_q.pop_front();
					if (got !== want) begin
						fail_cnt++;
						if (fail_cnt <= 10)
							$display("mismatch at result %0d: expected char %02h valid %0b last %0b len %0d repl %0d, got char %02h valid %0b last %0b len %0d repl %0d",
								checked_cnt, want.ch, want.valid, want.last, want.length, want.total,
								got.ch, got.valid, got.last, got.length, got.total);
					end
				end
				stall_left = $urandom_range(0, idle_max);
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("no traffic for %0d cycles, %0d result items outstanding",
					quiet, expected_q.size());
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	task automatic push_item(input logic [7:0] c, input logic is_last, input logic drain);
		text_q.push_back('{ch: c, last: is_last, drain: drain});
	endtask

	task automatic queue_bytes(input logic [63:0] chars, input int cnt, input bit drain_last);
		for (int i = 0; i < cnt; i++)
			push_item(chars[8*i +: 8], i == cnt - 1, drain_last && i == cnt - 1);
	endtask

	task automatic wait_idle();
		while (text_q.size() != 0 || in_ch.valid || predicted_cnt != checked_cnt)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [63:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= CFG_ADDR_W'(8 * int'(idx));
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_PATTERN_BYTES: pat_bytes = value;
			REG_PATTERN_LENGTH: begin
				pat_len = value[3:0];
				held_n  = 0;   // held bytes are dropped on a length write
			end
			REG_REPLACEMENT_BYTES: rep_bytes = value;
			REG_REPLACEMENT_LENGTH: rep_len = value[3:0];
			default: ;
		endcase
		reg_writes++;
	endtask

	task automatic configure(input logic [63:0] pat, input logic [3:0] plen,
			input logic [63:0] rep, input logic [3:0] rlen);
		write_reg(REG_PATTERN_BYTES, pat);
		write_reg(REG_PATTERN_LENGTH, 64'(plen));
		write_reg(REG_REPLACEMENT_BYTES, rep);
		write_reg(REG_REPLACEMENT_LENGTH, 64'(rlen));
	endtask

	// Text built mostly from whole and partial copies of the pattern.
	task automatic queue_random_text(input int len);
		int k, j, pick, cut;
		logic [7:0] b;
		k = 0;
		while (k < len) begin
			pick = $urandom_range(0, 9);
			if (pick < 4) cut = pattern_span();
			else if (pick < 6) cut = $urandom_range(1, pattern_span());
			else cut = 1;
			for (j = 0; j < cut && k < len; j++) begin
				if (pick < 6) b = pat_bytes[8*j +: 8];
				else if (pick < 8) b = pat_bytes[8*$urandom_range(0, 7) +: 8];
				else if (pick == 8) b = 8'($urandom_range(0, 255));
				else b = rep_bytes[8*$urandom_range(0, 7) +: 8];
				push_item(b, k == len - 1, $urandom_range(0, 49) == 0);
				k++;
			end
		end
	endtask

	initial begin : stimulus
		int phase, rand_items, len;
		logic [3:0]  plen, rlen;
		logic [63:0] pat;
		arst_n        = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		in_ch.valid   = 1'b0;
		in_ch.in_char = '0;
		in_ch.in_last = 1'b0;
		out_ch.ready  = 1'b0;
		pat_bytes     = '0;
		pat_len       = 4'd1;
		rep_bytes     = '0;
		rep_len       = 4'd0;
		held_bytes    = '{default: '0};
		held_n        = 0;
		bytes_written = 0;
		matches_found = 0;
		predicted_cnt = 0;
		checked_cnt   = 0;
		items_sent    = 0;
		texts_sent    = 0;
		reg_writes    = 0;
		fail_cnt      = 0;
		idle_max      = 13;
		quiet         = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: a zero byte is the pattern, matches are deleted
		push_item(8'h00, 1'b0, 1'b0);
		push_item(8'hFF, 1'b1, 1'b0);
		wait_idle();

		// "ab" -> "XYZ" on "aabxa"; the final 'a' is still held and gets flushed
		configure(64'h6261, 4'd2, 64'h5A5958, 4'd3);
		queue_bytes(64'h61_78_62_61_61, 5, 1'b1);
		wait_idle();

		// whole text deleted: only a bare end marker comes out
		configure(64'h71, 4'd1, 64'h0, 4'd0);
		push_item(8'h71, 1'b1, 1'b0);
		wait_idle();

		// length rewrite mid-text drops "ab", so the following 'c' is no match
		configure(64'h636261, 4'd3, 64'h21, 4'd1);
		queue_bytes(64'h6261, 2, 1'b0);
		text_q[text_q.size()-1].last = 1'b0;
		wait_idle();
		write_reg(REG_PATTERN_LENGTH, 64'd3);
		push_item(8'h63, 1'b1, 1'b0);
		wait_idle();

		// out-of-range lengths: 0 acts as 1, 15 as 8, 12 as 8
		configure(64'h7A, 4'd0, '1, 4'd15);
		push_item(8'h7A, 1'b1, 1'b0);
		wait_idle();
		configure('1, 4'd12, 64'h0, 4'd0);
		queue_bytes('1, 8, 1'b0);
		text_q[text_q.size()-1].last = 1'b0;
		push_item(8'h00, 1'b1, 1'b0);
		wait_idle();

		// one text with no idling on either side: every byte is replaced
		configure(64'h41, 4'd1, 64'h42, 4'd1);
		idle_max = 0;
		for (int i = 0; i < RATE_ITEMS; i++)
			push_item(8'h41, i == RATE_ITEMS - 1, 1'b0);
		wait_idle();

		phase = 0;
		rand_items = 0;
		while (rand_items < RANDOM_ITEMS) begin
			if (phase == 0) begin
				plen = 4'd8;
				rlen = 4'd8;
			end else if (phase == 1) begin
				plen = 4'd1;
				rlen = 4'd0;
			end else begin
				plen = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
					: 4'($urandom_range(1, 4));
				rlen = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
					: 4'($urandom_range(0, 8));
			end
			if ($urandom_range(0, 3) == 0) begin
				pat = {$urandom, $urandom};
			end else begin
				for (int j = 0; j < 8; j++)
					case ($urandom_range(0, 3))
						0: pat[8*j +: 8] = 8'h00;
						1: pat[8*j +: 8] = 8'hFF;
						2: pat[8*j +: 8] = 8'h61;
						default: pat[8*j +: 8] = 8'h62;
					endcase
			end
			configure(pat, plen, {$urandom, $urandom}, rlen);
			idle_max = ($urandom_range(0, 3) == 0) ? 0 : 13;
			repeat ($urandom_range(2, 6)) begin
				len = $urandom_range(1, 12);
				queue_random_text(len);
				rand_items += len;
			end
			wait_idle();
			phase++;
		end

		if (expected_q.size() != 0) begin
			fail_cnt++;
			$display("%0d expected result items never arrived", expected_q.size());
		end
		$display("run covered %0d texts, %0d text bytes in, %0d result items checked",
			texts_sent, items_sent, checked_cnt);
		$display("%0d register writes over %0d random settings, %0d failures",
			reg_writes, phase, fail_cnt);
		if (fail_cnt == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
